[src/tcspq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcspq_pkg: shared types and constants for the two-class priority queue
// Item layouts for both channels, action codes and the per-FIFO flag bundle.
// ----------------------------------------------------------------------------
package tcspq_pkg;

  // Fixed field widths of the item formats
  localparam int ID_W    = 16;
  localparam int TOTAL_W = 6;

  // Action codes
  localparam logic [1:0] ACT_ENQ   = 2'd0;
  localparam logic [1:0] ACT_DEQ   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // Request item
  typedef struct packed {
    logic [1:0]      action;
    logic [ID_W-1:0] item_id;
    logic            priority_class;
  } op_t;

  // Result item
  typedef struct packed {
    logic [ID_W-1:0]    served_id;
    logic               served_valid;
    logic               dropped;
    logic               all_empty;
    logic [TOTAL_W-1:0] total_items;
    logic [ID_W-1:0]    head_id;
    logic               head_valid;
    logic [ID_W-1:0]    tail_id;
    logic               tail_valid;
  } res_t;

  // Occupancy flags of one FIFO
  typedef struct packed {
    logic empty;       // before the current step
    logic full;        // before the current step
    logic empty_next;  // after the current step
  } fifo_flags_t;

endpackage

[src/tcspq_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcspq_fifo: one class FIFO
// Circular store with head index and fill count. The oldest entry is kept in
// a read register (read at the post-step head, bypassed on a same-address
// write) and the newest entry in a tail register, so both peeks are ready.
// ----------------------------------------------------------------------------
module tcspq_fifo #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         push,
  input  logic                         pop,
  input  logic [DATA_W-1:0]            wdata,
  output tcspq_pkg::fifo_flags_t       flags,
  output logic [$clog2(DEPTH+1)-1:0]   fill_next,
  output logic [DATA_W-1:0]            front,
  output logic [DATA_W-1:0]            tail_next
);
  import tcspq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     head;
  logic [AW-1:0]     head_next;
  logic [FW-1:0]     fill;
  logic [DATA_W-1:0] tail;
  logic [AW:0]       wsum;
  logic [AW-1:0]     waddr;

  // Write slot: (head + fill) mod DEPTH, one compare-subtract
  assign wsum  = (AW+1)'(head) + (AW+1)'(fill);
  assign waddr = (wsum >= (AW+1)'(DEPTH)) ? AW'(wsum - (AW+1)'(DEPTH)) : AW'(wsum);

  // Head advance with wrap
  always_comb begin
    head_next = head;
    if (pop) begin
      head_next = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
    end
  end

  assign fill_next = fill + FW'(push) - FW'(pop);
  assign tail_next = push ? wdata : tail;

  assign flags.empty      = (fill == '0);
  assign flags.full       = (fill == FW'(DEPTH));
  assign flags.empty_next = (fill_next == '0);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  // Store and front read register, advanced once per step
  always_ff @(posedge clk) begin
    if (step) begin
      if (push) begin
        mem[waddr] <= wdata;
      end
      front <= (push && waddr == head_next) ? wdata : mem[head_next];
      tail  <= tail_next;
    end
  end

endmodule

[src/two_class_strict_priority_queue.sv]
`timescale 1ns / 1ps
// An accepted item waits in the input register; a step through the FIFOs, taken
// once the result register is free or being taken, then loads the result
// register. Throughput: one item per cycle while res_ready keeps the output
// moving; the single-port FIFO update bounds it.
// Reset clears both FIFOs (head and fill) and the pipeline valids; store
// contents are left as they are and never read before written.
// ----------------------------------------------------------------------------
// two_class_strict_priority_queue: strict-priority pair of FIFOs
// Enqueue to the class FIFO (drop when full), dequeue priority first, and
// report occupancy and front/back peeks after each item.
// ----------------------------------------------------------------------------
module two_class_strict_priority_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_ready,
  input  tcspq_pkg::op_t    op,
  output logic              res_valid,
  input  logic              res_ready,
  output tcspq_pkg::res_t   res
);
  import tcspq_pkg::*;

  localparam int SW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  // Input register
  logic op_reg_valid;
  op_t  op_reg;
  logic advance;
  logic step;

  assign advance  = !res_valid || res_ready;
  assign step     = op_reg_valid && advance;
  assign op_ready = !op_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_reg_valid <= 1'b0;
    end else if (op_ready) begin
      op_reg_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid && op_ready) begin
      op_reg <= op;
    end
  end

  // Operation decode
  logic              is_enq;
  logic              is_deq;
  logic              p_push, p_pop, r_push, r_pop;
  logic [SW-1:0]     wdata;
  fifo_flags_t       p_flags, r_flags;
  logic [FW-1:0]     p_fill_next, r_fill_next;
  logic [SW-1:0]     p_front, r_front, p_tail_next, r_tail_next;

  assign is_enq = step && (op_reg.action == ACT_ENQ);
  assign is_deq = step && (op_reg.action == ACT_DEQ);
  assign wdata  = op_reg.item_id[SW-1:0];

  assign p_push = is_enq && op_reg.priority_class && !p_flags.full;
  assign r_push = is_enq && !op_reg.priority_class && !r_flags.full;
  assign p_pop  = is_deq && !p_flags.empty;
  assign r_pop  = is_deq && p_flags.empty && !r_flags.empty;

  tcspq_fifo #(.DEPTH(QUEUE_DEPTH), .DATA_W(SW)) u_prio (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .push      (p_push),
    .pop       (p_pop),
    .wdata     (wdata),
    .flags     (p_flags),
    .fill_next (p_fill_next),
    .front     (p_front),
    .tail_next (p_tail_next)
  );

  tcspq_fifo #(.DEPTH(QUEUE_DEPTH), .DATA_W(SW)) u_reg (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .push      (r_push),
    .pop       (r_pop),
    .wdata     (wdata),
    .flags     (r_flags),
    .fill_next (r_fill_next),
    .front     (r_front),
    .tail_next (r_tail_next)
  );

  // Post-step status
  logic [FW:0]         total_full;
  logic [ID_W-1:0]     served_id_next;
  logic [ID_W-1:0]     tail_id_next;

  assign total_full = (FW+1)'(p_fill_next) + (FW+1)'(r_fill_next);

  always_comb begin
    served_id_next = '0;
    if (p_pop) begin
      served_id_next = ID_W'(p_front);
    end else if (r_pop) begin
      served_id_next = ID_W'(r_front);
    end
  end

  always_comb begin
    tail_id_next = '0;
    if (!r_flags.empty_next) begin
      tail_id_next = ID_W'(r_tail_next);
    end else if (!p_flags.empty_next) begin
      tail_id_next = ID_W'(p_tail_next);
    end
  end

  // Result register; the head peek is taken from the FIFO front registers,
  // which load on the same step as this register
  logic               r_served_valid;
  logic [ID_W-1:0]    r_served_id;
  logic               r_dropped;
  logic               r_all_empty;
  logic [TOTAL_W-1:0] r_total;
  logic               r_head_valid;
  logic               r_head_prio;
  logic [ID_W-1:0]    r_tail_id;
  logic               r_tail_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= op_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      r_served_valid <= p_pop || r_pop;
      r_served_id    <= served_id_next;
      r_dropped      <= is_enq && (op_reg.priority_class ? p_flags.full : r_flags.full);
      r_all_empty    <= (total_full == '0);
      r_total        <= TOTAL_W'(total_full);
      r_head_valid   <= !p_flags.empty_next || !r_flags.empty_next;
      r_head_prio    <= !p_flags.empty_next;
      r_tail_id      <= tail_id_next;
      r_tail_valid   <= !p_flags.empty_next || !r_flags.empty_next;
    end
  end

  // Result item
  always_comb begin
    res.served_id    = r_served_id;
    res.served_valid = r_served_valid;
    res.dropped      = r_dropped;
    res.all_empty    = r_all_empty;
    res.total_items  = r_total;
    res.head_valid   = r_head_valid;
    res.tail_id      = r_tail_id;
    res.tail_valid   = r_tail_valid;
    res.head_id      = '0;
    if (r_head_valid) begin
      res.head_id = r_head_prio ? ID_W'(p_front) : ID_W'(r_front);
    end
  end

endmodule
